FILE: rtl/system_control_coprocessor_regs_core_macros.svh
// assertion macros shared by the register bank logic
`ifndef SYSTEM_CONTROL_COPROCESSOR_REGS_CORE_MACROS_SVH
`define SYSTEM_CONTROL_COPROCESSOR_REGS_CORE_MACROS_SVH

`ifndef SYNTHESIS
// plain property checked on every clock edge outside reset
`define SCCR_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("sccr assertion failed");
// overlapped implication checked on every clock edge outside reset
`define SCCR_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sccr implication failed");
// next-cycle implication checked on every clock edge outside reset
`define SCCR_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sccr next-cycle implication failed");
`else
`define SCCR_ASSERT(name, clk, rstn, prop)
`define SCCR_ASSERT_IMP(name, clk, rstn, ante, cons)
`define SCCR_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/sccr_pkg.sv
`timescale 1ns / 1ps

package sccr_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_WAKE  = 2'd2;

    // fixed read-only words
    localparam logic [31:0] ID_CODE    = 32'h4104_9460;
    localparam logic [31:0] CACHE_TYPE = 32'h0F0D_2112;
    localparam logic [31:0] TCM_SIZE   = 32'h0014_0140;

    // reset values of the stored registers
    localparam logic [31:0] PERM_RESET = 32'h2222_2222;
    localparam logic [31:0] DTCM_RESET = 32'h0080_000A;
    localparam logic [31:0] ITCM_RESET = 32'h0000_000C;

    localparam logic [31:0] TCM_MASK  = 32'hFFFF_FFC0;
    localparam logic [27:0] VEC_HIGH  = 28'hFFF_0000;

    // bank address map
    localparam int ADDR_W = 5;
    localparam int REGION_BASE = 16;
    localparam logic [ADDR_W-1:0] ADDR_CTRL   = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_DCFG   = 5'd1;
    localparam logic [ADDR_W-1:0] ADDR_ICFG   = 5'd2;
    localparam logic [ADDR_W-1:0] ADDR_WBUF   = 5'd3;
    localparam logic [ADDR_W-1:0] ADDR_DPERM  = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_IPERM  = 5'd5;
    localparam logic [ADDR_W-1:0] ADDR_DLOCK  = 5'd6;
    localparam logic [ADDR_W-1:0] ADDR_ILOCK  = 5'd7;
    localparam logic [ADDR_W-1:0] ADDR_DTCM   = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_ITCM   = 5'd9;
    localparam logic [ADDR_W-1:0] ADDR_REGION = 5'(REGION_BASE);

    typedef struct packed {
        logic [1:0]  operation;
        logic        user_mode;
        logic [3:0]  primary_reg;
        logic [3:0]  secondary_reg;
        logic [2:0]  first_opcode;
        logic [2:0]  second_opcode;
        logic [31:0] write_data;
    } in_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] read_data;
        logic        repeat_instruction;
        logic        enable_master_irq;
        logic        big_endian_mode;
        logic [27:0] vector_base;
        logic        load_thumb_disable;
        logic [31:0] data_tcm_base;
        logic [31:0] instr_tcm_base;
    } out_t;

    // what one decoded access does
    typedef enum logic [2:0] {
        K_NONE,
        K_CONST,
        K_READ,
        K_WRITE,
        K_WAIT,
        K_WAKE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       const_data;
    } dec_t;

    // bank access request
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [31:0]       wr_data;
    } bank_req_t;

    // value of an entry that was never written
    function automatic logic [31:0] reset_value(input logic [ADDR_W-1:0] addr);
        logic [31:0] val;
        val = 32'h0;
        if (addr == ADDR_DPERM || addr == ADDR_IPERM) begin
            val = PERM_RESET;
        end else if (addr == ADDR_DTCM) begin
            val = DTCM_RESET;
        end else if (addr == ADDR_ITCM) begin
            val = ITCM_RESET;
        end
        return val;
    endfunction

endpackage

FILE: rtl/system_control_coprocessor_regs_core.sv
`timescale 1ns / 1ps
// System control coprocessor register bank. Each input beat is a register
// read, a register write or an interrupt wake, and gives exactly one result
// beat. The stored registers live in a small synchronous array with a
// registered read. The idle state accepts the beat and reads the bank; the
// exec state, once the output register is free, merges, writes back and
// loads the output register. A new beat is taken only after the return
// to idle. Reset leaves every entry at its reset value at once through
// per-entry valid bits, with no clearing pass. Control, TCM region and
// wait flags are mirrored in flip-flops so the mode outputs come with every
// result.

`include "system_control_coprocessor_regs_core_macros.svh"

module system_control_coprocessor_regs_core
    import sccr_pkg::*;
#(
    parameter int REGION_COUNT = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int DEPTH = REGION_BASE + REGION_COUNT;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    dec_t        dec;
    dec_t        dec_reg;
    logic [31:0] wdata_reg;
    bank_req_t   req;
    logic [31:0] bank_rd_data;

    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;
    logic [31:0] ctrl_reg, ctrl_next;
    logic [31:0] dtcm_reg, dtcm_next;
    logic [31:0] itcm_reg, itcm_next;
    logic        armed_reg, armed_next;
    logic        waiting_reg, waiting_next;

    logic        in_fire;
    logic        out_free;
    logic        done;

    sccr_decode #(
        .REGION_COUNT(REGION_COUNT)
    ) u_decode (
        .beat(s_data),
        .dec (dec)
    );

    sccr_bank #(
        .DEPTH(DEPTH)
    ) u_bank (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (req),
        .rd_data(bank_rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign done     = (state_reg == ST_EXEC) && out_free;

    // bank read on accept, write back on completion
    always_comb begin
        req.rd_en   = in_fire;
        req.rd_addr = dec.addr;
        req.wr_en   = done && (dec_reg.kind == K_WRITE);
        req.wr_addr = dec_reg.addr;
        req.wr_data = wdata_reg;
    end

    // capture the decoded beat
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            dec_reg   <= dec;
            wdata_reg <= s_data.write_data;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // merge step: mirrors, wait flags and result beat
    always_comb begin
        ctrl_next    = ctrl_reg;
        dtcm_next    = dtcm_reg;
        itcm_next    = itcm_reg;
        armed_next   = armed_reg;
        waiting_next = waiting_reg;
        m_data_next  = '0;
        m_data_next.accepted = (dec_reg.kind != K_NONE);
        unique case (dec_reg.kind)
            K_CONST: begin
                m_data_next.read_data = dec_reg.const_data;
            end
            K_READ: begin
                m_data_next.read_data = bank_rd_data;
            end
            K_WRITE: begin
                if (dec_reg.addr == ADDR_CTRL) begin
                    ctrl_next = wdata_reg;
                end
                if (dec_reg.addr == ADDR_DTCM) begin
                    dtcm_next = wdata_reg;
                end
                if (dec_reg.addr == ADDR_ITCM) begin
                    itcm_next = wdata_reg;
                end
            end
            K_WAIT: begin
                if (armed_reg) begin
                    if (!waiting_reg) begin
                        armed_next = 1'b0;
                    end else begin
                        m_data_next.repeat_instruction = 1'b1;
                    end
                end else begin
                    armed_next   = 1'b1;
                    waiting_next = 1'b1;
                    m_data_next.repeat_instruction = 1'b1;
                    m_data_next.enable_master_irq  = 1'b1;
                end
            end
            K_WAKE: begin
                waiting_next = 1'b0;
            end
            K_NONE: begin
                m_data_next.accepted = 1'b0;
            end
            default: begin
                m_data_next.accepted = 1'b0;
            end
        endcase
        m_data_next.big_endian_mode    = ctrl_next[7];
        m_data_next.vector_base        = ctrl_next[13] ? VEC_HIGH : 28'h0;
        m_data_next.load_thumb_disable = !ctrl_next[15];
        m_data_next.data_tcm_base      = dtcm_next & TCM_MASK;
        m_data_next.instr_tcm_base     = itcm_next & TCM_MASK;
    end

    // output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            ctrl_reg    <= 32'h0;
            dtcm_reg    <= DTCM_RESET;
            itcm_reg    <= ITCM_RESET;
            armed_reg   <= 1'b0;
            waiting_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (done) begin
                ctrl_reg    <= ctrl_next;
                dtcm_reg    <= dtcm_next;
                itcm_reg    <= itcm_next;
                armed_reg   <= armed_next;
                waiting_reg <= waiting_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `SCCR_ASSERT_NXT(a_fire_to_exec, aclk, aresetn, in_fire, state_reg == ST_EXEC)
    `SCCR_ASSERT_IMP(a_wait_needs_arm, aclk, aresetn, waiting_reg, armed_reg)
    `SCCR_ASSERT_IMP(a_irq_with_repeat, aclk, aresetn, m_valid && m_data.enable_master_irq, m_data.repeat_instruction)
    `SCCR_ASSERT_IMP(a_result_from_exec, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_EXEC))
    `SCCR_ASSERT_IMP(a_vector_values, aclk, aresetn, m_valid, m_data.vector_base == 28'h0 || m_data.vector_base == VEC_HIGH)

endmodule

FILE: rtl/sccr_decode.sv
`timescale 1ns / 1ps

module sccr_decode
    import sccr_pkg::*;
#(
    parameter int REGION_COUNT = 8
) (
    input  in_t  beat,
    output dec_t dec
);

    localparam logic [4:0] RC = 5'(REGION_COUNT);

    logic              hit;
    logic [ADDR_W-1:0] hit_addr;
    logic              crm0;
    logic              priv_ok;

    assign crm0    = (beat.secondary_reg == 4'd0);
    assign priv_ok = !beat.user_mode && (beat.first_opcode == 3'd0);

    // stored register lookup by crn, crm and opc2
    always_comb begin
        hit      = 1'b0;
        hit_addr = ADDR_CTRL;
        unique case (beat.primary_reg)
            4'd1: begin
                if (crm0 && beat.second_opcode == 3'd0) begin
                    hit = 1'b1; hit_addr = ADDR_CTRL;
                end
            end
            4'd2: begin
                if (crm0 && beat.second_opcode == 3'd0) begin
                    hit = 1'b1; hit_addr = ADDR_DCFG;
                end else if (crm0 && beat.second_opcode == 3'd1) begin
                    hit = 1'b1; hit_addr = ADDR_ICFG;
                end
            end
            4'd3: begin
                if (crm0 && beat.second_opcode == 3'd0) begin
                    hit = 1'b1; hit_addr = ADDR_WBUF;
                end
            end
            4'd5: begin
                if (crm0 && beat.second_opcode == 3'd2) begin
                    hit = 1'b1; hit_addr = ADDR_DPERM;
                end else if (crm0 && beat.second_opcode == 3'd3) begin
                    hit = 1'b1; hit_addr = ADDR_IPERM;
                end
            end
            4'd6: begin
                if (beat.second_opcode == 3'd0 && {1'b0, beat.secondary_reg} < RC) begin
                    hit      = 1'b1;
                    hit_addr = ADDR_REGION + {1'b0, beat.secondary_reg};
                end
            end
            4'd9: begin
                if (crm0 && beat.second_opcode == 3'd0) begin
                    hit = 1'b1; hit_addr = ADDR_DLOCK;
                end else if (crm0 && beat.second_opcode == 3'd1) begin
                    hit = 1'b1; hit_addr = ADDR_ILOCK;
                end else if (beat.secondary_reg == 4'd1 && beat.second_opcode == 3'd0) begin
                    hit = 1'b1; hit_addr = ADDR_DTCM;
                end else if (beat.secondary_reg == 4'd1 && beat.second_opcode == 3'd1) begin
                    hit = 1'b1; hit_addr = ADDR_ITCM;
                end
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    // access kind
    always_comb begin
        dec.kind       = K_NONE;
        dec.addr       = hit_addr;
        dec.const_data = ID_CODE;
        if (beat.second_opcode == 3'd1) begin
            dec.const_data = CACHE_TYPE;
        end else if (beat.second_opcode == 3'd2) begin
            dec.const_data = TCM_SIZE;
        end
        priority if (beat.operation == OP_WAKE) begin
            dec.kind = K_WAKE;
        end else if (beat.operation == OP_READ && priv_ok) begin
            if (beat.primary_reg == 4'd0 && crm0) begin
                dec.kind = K_CONST;
            end else if (hit) begin
                dec.kind = K_READ;
            end
        end else if (beat.operation == OP_WRITE && priv_ok) begin
            if (beat.primary_reg == 4'd7) begin
                if (crm0 && beat.second_opcode == 3'd4) begin
                    dec.kind = K_WAIT;
                end
            end else if (hit) begin
                dec.kind = K_WRITE;
            end
        end else begin
            dec.kind = K_NONE;
        end
    end

endmodule

FILE: rtl/sccr_bank.sv
`timescale 1ns / 1ps

module sccr_bank
    import sccr_pkg::*;
#(
    parameter int DEPTH = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  bank_req_t   req,
    output logic [31:0] rd_data
);

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [31:0]      rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // per-entry valid bits, cleared at once by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // registered read, unwritten entries give their reset value
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr]
                                                  : reset_value(req.rd_addr);
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/cp15_map_pkg.sv
`timescale 1ns / 1ps

package cp15_map_pkg;

    // operation code that the bank ignores
    localparam logic [1:0] OP_NONE = 2'd3;

    // primary register numbers
    localparam logic [3:0] CRN_ID        = 4'd0;
    localparam logic [3:0] CRN_CTRL      = 4'd1;
    localparam logic [3:0] CRN_CACHE_CFG = 4'd2;
    localparam logic [3:0] CRN_WBUF      = 4'd3;
    localparam logic [3:0] CRN_PERM      = 4'd5;
    localparam logic [3:0] CRN_REGION    = 4'd6;
    localparam logic [3:0] CRN_CACHE_OPS = 4'd7;
    localparam logic [3:0] CRN_LOCK_TCM  = 4'd9;

    // secondary register numbers
    localparam logic [3:0] CRM_MAIN = 4'd0;
    localparam logic [3:0] CRM_TCM  = 4'd1;

    // second opcode values
    localparam logic [2:0] OPC2_DATA       = 3'd0;
    localparam logic [2:0] OPC2_INSTR      = 3'd1;
    localparam logic [2:0] OPC2_CACHE_TYPE = 3'd1;
    localparam logic [2:0] OPC2_TCM_SIZE   = 3'd2;
    localparam logic [2:0] OPC2_DPERM      = 3'd2;
    localparam logic [2:0] OPC2_IPERM      = 3'd3;
    localparam logic [2:0] OPC2_WFI        = 3'd4;

    // first opcode that every decoded read or write needs
    localparam logic [2:0] OPC1_CP15 = 3'd0;

endpackage

FILE: tb/cp15_bank_checker.sv
`timescale 1ns / 1ps

module cp15_bank_checker
    import sccr_pkg::*;
    import cp15_map_pkg::*;
#(
    parameter int REGION_COUNT = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   fail_count,
    output int   pending_count
);

    // slots of the shadow register file
    localparam int SLOT_CTRL   = 0;
    localparam int SLOT_DCFG   = 1;
    localparam int SLOT_ICFG   = 2;
    localparam int SLOT_WBUF   = 3;
    localparam int SLOT_DPERM  = 4;
    localparam int SLOT_IPERM  = 5;
    localparam int SLOT_DLOCK  = 6;
    localparam int SLOT_ILOCK  = 7;
    localparam int SLOT_DTCM   = 8;
    localparam int SLOT_ITCM   = 9;
    localparam int SLOT_REGION = 10;
    localparam int SLOT_COUNT  = 18;
    localparam int NO_SLOT     = -1;

    logic [31:0] shadow_regs [SLOT_COUNT];
    logic        wait_armed;
    logic        waiting_for_irq;
    out_t        answers_due [$];
    out_t        oldest;
    int          fails = 0;

    assign fail_count = fails;

    // map an access address onto a shadow slot
    function automatic int reg_slot(logic [3:0] crn, logic [3:0] crm, logic [2:0] op2);
        int slot;
        slot = NO_SLOT;
        case (crn)
            CRN_CTRL: begin
                if (crm == CRM_MAIN && op2 == OPC2_DATA) slot = SLOT_CTRL;
            end
            CRN_CACHE_CFG: begin
                if (crm == CRM_MAIN && op2 == OPC2_DATA) slot = SLOT_DCFG;
                if (crm == CRM_MAIN && op2 == OPC2_INSTR) slot = SLOT_ICFG;
            end
            CRN_WBUF: begin
                if (crm == CRM_MAIN && op2 == OPC2_DATA) slot = SLOT_WBUF;
            end
            CRN_PERM: begin
                if (crm == CRM_MAIN && op2 == OPC2_DPERM) slot = SLOT_DPERM;
                if (crm == CRM_MAIN && op2 == OPC2_IPERM) slot = SLOT_IPERM;
            end
            CRN_REGION: begin
                if (op2 == OPC2_DATA && int'(crm) < REGION_COUNT && crm < 4'd8)
                    slot = SLOT_REGION + int'(crm);
            end
            CRN_LOCK_TCM: begin
                if (crm == CRM_MAIN && op2 == OPC2_DATA) slot = SLOT_DLOCK;
                if (crm == CRM_MAIN && op2 == OPC2_INSTR) slot = SLOT_ILOCK;
                if (crm == CRM_TCM && op2 == OPC2_DATA) slot = SLOT_DTCM;
                if (crm == CRM_TCM && op2 == OPC2_INSTR) slot = SLOT_ITCM;
            end
            default: slot = NO_SLOT;
        endcase
        return slot;
    endfunction

    // perform one access on the shadow state and form its answer
    function automatic out_t access_bank(in_t acc);
        out_t        res;
        int          slot;
        logic [31:0] ctrl;
        res = '0;
        if (acc.operation == OP_WAKE) begin
            waiting_for_irq = 1'b0;
            res.accepted = 1'b1;
        end else if ((acc.operation == OP_READ || acc.operation == OP_WRITE) &&
                     !acc.user_mode && acc.first_opcode == OPC1_CP15) begin
            if (acc.operation == OP_READ) begin
                if (acc.primary_reg == CRN_ID && acc.secondary_reg == CRM_MAIN) begin
                    if (acc.second_opcode == OPC2_CACHE_TYPE)
                        res.read_data = CACHE_TYPE;
                    else if (acc.second_opcode == OPC2_TCM_SIZE)
                        res.read_data = TCM_SIZE;
                    else
                        res.read_data = ID_CODE;
                    res.accepted = 1'b1;
                end else begin
                    slot = reg_slot(acc.primary_reg, acc.secondary_reg, acc.second_opcode);
                    if (slot != NO_SLOT) begin
                        res.read_data = shadow_regs[slot];
                        res.accepted = 1'b1;
                    end
                end
            end else if (acc.primary_reg == CRN_CACHE_OPS) begin
                // wait for interrupt: arm, keep repeating, release after wake
                if (acc.secondary_reg == CRM_MAIN && acc.second_opcode == OPC2_WFI) begin
                    res.accepted = 1'b1;
                    if (wait_armed) begin
                        if (!waiting_for_irq) wait_armed = 1'b0;
                        else res.repeat_instruction = 1'b1;
                    end else begin
                        wait_armed = 1'b1;
                        waiting_for_irq = 1'b1;
                        res.repeat_instruction = 1'b1;
                        res.enable_master_irq = 1'b1;
                    end
                end
            end else if (acc.primary_reg != CRN_ID) begin
                slot = reg_slot(acc.primary_reg, acc.secondary_reg, acc.second_opcode);
                if (slot != NO_SLOT) begin
                    shadow_regs[slot] = acc.write_data;
                    res.accepted = 1'b1;
                end
            end
        end
        // mode outputs follow the state after the access
        ctrl = shadow_regs[SLOT_CTRL];
        res.big_endian_mode = ctrl[7];
        res.vector_base = ctrl[13] ? VEC_HIGH : 28'h0;
        res.load_thumb_disable = ~ctrl[15];
        res.data_tcm_base = shadow_regs[SLOT_DTCM] & TCM_MASK;
        res.instr_tcm_base = shadow_regs[SLOT_ITCM] & TCM_MASK;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // track accepted beats on both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) shadow_regs[i] = 32'h0;
            shadow_regs[SLOT_DPERM] = PERM_RESET;
            shadow_regs[SLOT_IPERM] = PERM_RESET;
            shadow_regs[SLOT_DTCM] = DTCM_RESET;
            shadow_regs[SLOT_ITCM] = ITCM_RESET;
            wait_armed = 1'b0;
            waiting_for_irq = 1'b0;
            answers_due.delete();
        end else begin
            if (s_valid && s_ready) answers_due.push_back(access_bank(s_data));
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fails++;
                end else begin
                    oldest = answers_due.pop_front();
                    check_field("accepted", 32'(oldest.accepted), 32'(m_data.accepted));
                    check_field("read_data", oldest.read_data, m_data.read_data);
                    check_field("repeat_instruction", 32'(oldest.repeat_instruction),
                                32'(m_data.repeat_instruction));
                    check_field("enable_master_irq", 32'(oldest.enable_master_irq),
                                32'(m_data.enable_master_irq));
                    check_field("big_endian_mode", 32'(oldest.big_endian_mode),
                                32'(m_data.big_endian_mode));
                    check_field("vector_base", 32'(oldest.vector_base),
                                32'(m_data.vector_base));
                    check_field("load_thumb_disable", 32'(oldest.load_thumb_disable),
                                32'(m_data.load_thumb_disable));
                    check_field("data_tcm_base", oldest.data_tcm_base, m_data.data_tcm_base);
                    check_field("instr_tcm_base", oldest.instr_tcm_base,
                                m_data.instr_tcm_base);
                end
            end
        end
        pending_count <= answers_due.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sccr_pkg::*;
    import cp15_map_pkg::*;

    localparam int REGION_COUNT = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 300;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int fail_count;
    int pending_count;
    int tx_idle_pct = 32;
    int rx_idle_pct = 63;
    logic stall_go = 1'b0;
    int stall_left = 0;
    int cycles = 0;

    system_control_coprocessor_regs_core #(
        .REGION_COUNT(REGION_COUNT)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    cp15_bank_checker #(
        .REGION_COUNT(REGION_COUNT)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always #10 aclk = ~aclk;

    // result side: random back-pressure, or a long hold-off on request
    always @(posedge aclk) begin
        if (stall_go) begin
            stall_left <= STALL_CYCLES;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // run length guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic in_t access(logic [1:0] op, logic user, logic [3:0] crn,
                                   logic [3:0] crm, logic [2:0] op1, logic [2:0] op2,
                                   logic [31:0] data);
        in_t b;
        b.operation = op;
        b.user_mode = user;
        b.primary_reg = crn;
        b.secondary_reg = crm;
        b.first_opcode = op1;
        b.second_opcode = op2;
        b.write_data = data;
        return b;
    endfunction

    function automatic logic [31:0] data_pattern();
        logic [31:0] d;
        case ($urandom_range(3))
            0: d = 32'h0;
            1: d = 32'hFFFF_FFFF;
            default: d = $urandom;
        endcase
        return d;
    endfunction

    // privileged read or write of a decoded register or of the id words
    function automatic in_t reg_target();
        in_t t;
        t = access(($urandom_range(1) == 0) ? OP_READ : OP_WRITE, 1'b0, CRN_CTRL,
                   CRM_MAIN, OPC1_CP15, OPC2_DATA, data_pattern());
        case ($urandom_range(11))
            0: t.primary_reg = CRN_CTRL;
            1: t.primary_reg = CRN_CACHE_CFG;
            2: begin
                t.primary_reg = CRN_CACHE_CFG;
                t.second_opcode = OPC2_INSTR;
            end
            3: t.primary_reg = CRN_WBUF;
            4: begin
                t.primary_reg = CRN_PERM;
                t.second_opcode = OPC2_DPERM;
            end
            5: begin
                t.primary_reg = CRN_PERM;
                t.second_opcode = OPC2_IPERM;
            end
            6: begin
                t.primary_reg = CRN_REGION;
                t.secondary_reg = 4'($urandom_range(REGION_COUNT - 1));
            end
            7: t.primary_reg = CRN_LOCK_TCM;
            8: begin
                t.primary_reg = CRN_LOCK_TCM;
                t.second_opcode = OPC2_INSTR;
            end
            9: begin
                t.primary_reg = CRN_LOCK_TCM;
                t.secondary_reg = CRM_TCM;
            end
            10: begin
                t.primary_reg = CRN_LOCK_TCM;
                t.secondary_reg = CRM_TCM;
                t.second_opcode = OPC2_INSTR;
            end
            default: begin
                t.primary_reg = CRN_ID;
                t.second_opcode = 3'($urandom_range(7));
            end
        endcase
        return t;
    endfunction

    // mostly well-formed accesses and wait/wake traffic, some noise
    function automatic in_t random_access();
        in_t b;
        int  pick;
        pick = $urandom_range(99);
        b = reg_target();
        if (pick < 15) begin
            b.operation = OP_WRITE;
            b.primary_reg = CRN_CACHE_OPS;
            b.secondary_reg = CRM_MAIN;
            b.second_opcode = OPC2_WFI;
        end else if (pick < 25) begin
            b.operation = OP_WAKE;
            b.user_mode = 1'($urandom_range(1));
        end else if (pick < 35) begin
            b.operation = 2'($urandom_range(3));
            b.user_mode = 1'($urandom_range(1));
            b.primary_reg = 4'($urandom);
            b.secondary_reg = 4'($urandom);
            b.first_opcode = 3'($urandom);
            b.second_opcode = 3'($urandom);
            b.write_data = $urandom;
        end else if (pick < 45) begin
            case ($urandom_range(3))
                0: b.user_mode = 1'b1;
                1: b.first_opcode = 3'($urandom_range(1, 7));
                2: b.secondary_reg = 4'($urandom_range(8, 15));
                default: b.second_opcode = 3'($urandom_range(4, 7));
            endcase
        end
        return b;
    endfunction

    // offer one beat, hold it until taken, then maybe go idle
    task automatic send_beat(in_t beat);
        s_data <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fixed words and reset values
        send_beat(access(OP_READ, 1'b0, CRN_ID, CRM_MAIN, OPC1_CP15, OPC2_DATA, 32'h0));
        send_beat(access(OP_READ, 1'b0, CRN_ID, CRM_MAIN, OPC1_CP15, OPC2_CACHE_TYPE, 32'h0));
        send_beat(access(OP_READ, 1'b0, CRN_ID, CRM_MAIN, OPC1_CP15, OPC2_TCM_SIZE, 32'h0));
        send_beat(access(OP_READ, 1'b0, CRN_ID, CRM_MAIN, OPC1_CP15, 3'd7, 32'h0));
        send_beat(access(OP_READ, 1'b0, CRN_PERM, CRM_MAIN, OPC1_CP15, OPC2_DPERM, 32'h0));
        send_beat(access(OP_READ, 1'b0, CRN_LOCK_TCM, CRM_TCM, OPC1_CP15, OPC2_DATA, 32'h0));
        send_beat(access(OP_READ, 1'b0, CRN_LOCK_TCM, CRM_TCM, OPC1_CP15, OPC2_INSTR, 32'h0));
        // control word all ones drives every mode output
        send_beat(access(OP_WRITE, 1'b0, CRN_CTRL, CRM_MAIN, OPC1_CP15, OPC2_DATA,
                         32'hFFFF_FFFF));
        send_beat(access(OP_READ, 1'b0, CRN_CTRL, CRM_MAIN, OPC1_CP15, OPC2_DATA, 32'h0));
        // refused: write to id words, user mode, bad opc1, unused operation code
        send_beat(access(OP_WRITE, 1'b0, CRN_ID, CRM_MAIN, OPC1_CP15, OPC2_DATA,
                         32'hFFFF_FFFF));
        send_beat(access(OP_READ, 1'b1, CRN_ID, CRM_MAIN, OPC1_CP15, OPC2_DATA, 32'h0));
        send_beat(access(OP_WRITE, 1'b1, CRN_CTRL, CRM_MAIN, OPC1_CP15, OPC2_DATA, 32'h0));
        send_beat(access(OP_READ, 1'b0, CRN_ID, CRM_MAIN, 3'd7, OPC2_DATA, 32'h0));
        send_beat(access(OP_NONE, 1'b0, CRN_CTRL, CRM_MAIN, OPC1_CP15, OPC2_DATA, 32'h0));
        send_beat(access(OP_WRITE, 1'b0, CRN_CTRL, CRM_MAIN, OPC1_CP15, OPC2_DATA, 32'h0));
        // wait entry, wait repeat, wake from user mode, wait release
        send_beat(access(OP_WRITE, 1'b0, CRN_CACHE_OPS, CRM_MAIN, OPC1_CP15, OPC2_WFI, 32'h0));
        send_beat(access(OP_WRITE, 1'b0, CRN_CACHE_OPS, CRM_MAIN, OPC1_CP15, OPC2_WFI, 32'h0));
        send_beat(access(OP_WAKE, 1'b1, CRN_ID, CRM_MAIN, OPC1_CP15, OPC2_DATA, 32'h0));
        send_beat(access(OP_WRITE, 1'b0, CRN_CACHE_OPS, CRM_MAIN, OPC1_CP15, OPC2_WFI, 32'h0));
        // last region, one past the last region
        send_beat(access(OP_WRITE, 1'b0, CRN_REGION, 4'(REGION_COUNT - 1), OPC1_CP15,
                         OPC2_DATA, 32'hFFFF_FFFF));
        send_beat(access(OP_READ, 1'b0, CRN_REGION, 4'(REGION_COUNT - 1), OPC1_CP15,
                         OPC2_DATA, 32'h0));
        send_beat(access(OP_READ, 1'b0, CRN_REGION, 4'(REGION_COUNT), OPC1_CP15,
                         OPC2_DATA, 32'h0));
        // tcm regions and permissions at the extremes
        send_beat(access(OP_WRITE, 1'b0, CRN_LOCK_TCM, CRM_TCM, OPC1_CP15, OPC2_DATA,
                         32'hFFFF_FFFF));
        send_beat(access(OP_WRITE, 1'b0, CRN_LOCK_TCM, CRM_TCM, OPC1_CP15, OPC2_INSTR, 32'h0));
        send_beat(access(OP_WRITE, 1'b0, CRN_PERM, CRM_MAIN, OPC1_CP15, OPC2_IPERM, 32'h0));
        send_beat(access(OP_READ, 1'b0, CRN_PERM, CRM_MAIN, OPC1_CP15, OPC2_IPERM, 32'h0));

        // random traffic, sender light and receiver heavy idling
        repeat (510) send_beat(random_access());
        wait_drained();

        // the other way round
        tx_idle_pct = 63;
        rx_idle_pct <= 32;
        repeat (510) send_beat(random_access());
        wait_drained();

        // no idling; first a long result hold-off to back the block up
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        stall_go <= 1'b1;
        @(posedge aclk);
        stall_go <= 1'b0;
        repeat (40) send_beat(random_access());
        repeat (470) send_beat(random_access());
        wait_drained();
        repeat (10) @(posedge aclk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
